### hw/rtl/dtlf_pkg.sv
package dtlf_pkg;

  // fixed sizes of the tree and the sample
  localparam int unsigned Nodes         = 256;
  localparam int unsigned Features      = 64;
  localparam int unsigned MaxCategories = 31;
  localparam int unsigned FracBits      = 16;

  localparam int unsigned NodeW  = $clog2(Nodes);
  localparam int unsigned FeatW  = $clog2(Features);
  localparam int unsigned CountW = 5;
  localparam int unsigned WordW  = 32;
  localparam int unsigned CatW   = WordW - FracBits;
  localparam int unsigned BitSelW = $clog2(WordW);

  // item function codes
  typedef enum logic [1:0] {
    FuncWriteNode  = 2'd0,
    FuncWriteValue = 2'd1,
    FuncWriteCount = 2'd2,
    FuncWalk       = 2'd3
  } func_e;

  // configuration register indexes
  localparam logic [7:0] CfgShuffleEnable  = 8'd0;
  localparam logic [7:0] CfgShuffleFeature = 8'd1;

  // one stored node entry
  typedef struct packed {
    logic              leaf;
    logic [FeatW-1:0]  feature;
    logic [WordW-1:0]  word;
    logic [NodeW-1:0]  left;
    logic [NodeW-1:0]  right;
  } node_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic fetch_node;
    logic fetch_feat;
    logic take_leaf;
    logic eval_step;
    logic out_load;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_walk;
    logic is_leaf;
    logic cat_err;
    logic last_move;
    logic out_free;
  } dp_status_t;

endpackage

### hw/rtl/decision_tree_leaf_finder_core.sv
// channel  | direction | handshake             | payload
// ---------+-----------+-----------------------+------------------------------------------
// in       | input     | in_valid_i / in_stall_o   | func, node entry, feature, shuffled value
// out      | output    | out_valid_o / out_stall_i | terminal_node, category_error, walk_overrun
// cfg      | input     | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// a write item goes from its accept straight to the done state, which loads its result.
// a walk passes splits until it reaches a leaf: each split is a node memory read, a
// feature value and count read, then the split test; the leaf costs a node read and a decode.
// a bad category or the move limit ends the walk right after that split test.
// one item is in work at a time; a finished result waits in the output register
// while the next item is accepted.
// reset (rst_ni, async, active low) clears control, configuration and count valid bits;
// node entries and feature values are undefined until written.
module decision_tree_leaf_finder_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [7:0]                         cfg_index_i,
  input  logic [31:0]                        cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [1:0]                         func_i,
  input  logic [dtlf_pkg::NodeW-1:0]         node_index_i,
  input  logic                               node_is_terminal_i,
  input  logic [dtlf_pkg::FeatW-1:0]         split_feature_i,
  input  logic [dtlf_pkg::WordW-1:0]         split_word_i,
  input  logic [dtlf_pkg::NodeW-1:0]         left_child_i,
  input  logic [dtlf_pkg::NodeW-1:0]         right_child_i,
  input  logic [dtlf_pkg::FeatW-1:0]         feature_index_i,
  input  logic signed [dtlf_pkg::WordW-1:0]  feature_value_i,
  input  logic [dtlf_pkg::CountW-1:0]        category_count_i,
  input  logic signed [dtlf_pkg::WordW-1:0]  shuffled_value_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [dtlf_pkg::NodeW-1:0]         terminal_node_o,
  output logic                               category_error_o,
  output logic                               walk_overrun_o
);
  import dtlf_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t sts;

  // configuration is always taken
  assign cfg_ready_o = 1'b1;

  // sequencer
  dtlf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // storage, split test and output register
  dtlf_datapath u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .func_i             (func_i),
    .node_index_i       (node_index_i),
    .node_is_terminal_i (node_is_terminal_i),
    .split_feature_i    (split_feature_i),
    .split_word_i       (split_word_i),
    .left_child_i       (left_child_i),
    .right_child_i      (right_child_i),
    .feature_index_i    (feature_index_i),
    .feature_value_i    (feature_value_i),
    .category_count_i   (category_count_i),
    .shuffled_value_i   (shuffled_value_i),
    .out_stall_i        (out_stall_i),
    .out_valid_o        (out_valid_o),
    .terminal_node_o    (terminal_node_o),
    .category_error_o   (category_error_o),
    .walk_overrun_o     (walk_overrun_o)
  );

endmodule

### hw/rtl/dtlf_ctrl.sv
module dtlf_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  dtlf_pkg::dp_status_t   sts_i,
  output dtlf_pkg::ctrl_cmd_t    cmd_o
);
  import dtlf_pkg::*;

  typedef enum logic [4:0] {
    StIdle   = 5'b00001,
    StFetch  = 5'b00010,
    StDecode = 5'b00100,
    StEval   = 5'b01000,
    StDone   = 5'b10000
  } state_e;

  state_e state_q, state_d;

  assign in_stall_o = (state_q != StIdle);

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = sts_i.is_walk ? StFetch : StDone;
        end
      end
      StFetch: begin
        cmd_o.fetch_node = 1'b1;
        state_d          = StDecode;
      end
      StDecode: begin
        if (sts_i.is_leaf) begin
          cmd_o.take_leaf = 1'b1;
          state_d         = StDone;
        end else begin
          cmd_o.fetch_feat = 1'b1;
          state_d          = StEval;
        end
      end
      StEval: begin
        cmd_o.eval_step = 1'b1;
        state_d         = (sts_i.cat_err || sts_i.last_move) ? StDone : StFetch;
      end
      StDone: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // node data is only decoded right after its fetch
  a_decode_after_fetch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StDecode |-> $past(state_q) == StFetch)
    else $error("decode without fetch");

  // a step is only evaluated on freshly fetched feature data
  a_eval_after_decode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StEval |-> $past(state_q) == StDecode)
    else $error("eval without decode");

  // an accepted item leads to a walk or straight to a result
  a_accept_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.accept |=> (state_q == StFetch || state_q == StDone))
    else $error("bad state after accept");

endmodule

### hw/rtl/dtlf_datapath.sv
module dtlf_datapath (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  dtlf_pkg::ctrl_cmd_t                    cmd_i,
  output dtlf_pkg::dp_status_t                   sts_o,
  input  logic                                   cfg_valid_i,
  input  logic [7:0]                             cfg_index_i,
  input  logic [31:0]                            cfg_data_i,
  input  logic [1:0]                             func_i,
  input  logic [dtlf_pkg::NodeW-1:0]             node_index_i,
  input  logic                                   node_is_terminal_i,
  input  logic [dtlf_pkg::FeatW-1:0]             split_feature_i,
  input  logic [dtlf_pkg::WordW-1:0]             split_word_i,
  input  logic [dtlf_pkg::NodeW-1:0]             left_child_i,
  input  logic [dtlf_pkg::NodeW-1:0]             right_child_i,
  input  logic [dtlf_pkg::FeatW-1:0]             feature_index_i,
  input  logic signed [dtlf_pkg::WordW-1:0]      feature_value_i,
  input  logic [dtlf_pkg::CountW-1:0]            category_count_i,
  input  logic signed [dtlf_pkg::WordW-1:0]      shuffled_value_i,
  input  logic                                   out_stall_i,
  output logic                                   out_valid_o,
  output logic [dtlf_pkg::NodeW-1:0]             terminal_node_o,
  output logic                                   category_error_o,
  output logic                                   walk_overrun_o
);
  import dtlf_pkg::*;

  // storage
  node_t             node_mem [Nodes];
  logic [WordW-1:0]  value_mem [Features];
  logic [CountW-1:0] count_mem [Features];
  logic [Features-1:0] count_vld_q;

  // configuration
  logic             shuf_en_q;
  logic [FeatW-1:0] shuf_feat_q;

  // walk registers
  logic [NodeW-1:0]  node_q;
  logic [NodeW-1:0]  moves_q;
  logic [WordW-1:0]  shuf_val_q;
  node_t             node_rd_q;
  logic [WordW-1:0]  value_rd_q;
  logic [CountW-1:0] count_rd_q;
  logic              count_vld_rd_q;
  logic              shuf_hit_q;

  // result and output registers
  logic [NodeW-1:0] res_node_q;
  logic             res_err_q;
  logic             res_ovr_q;
  logic             out_valid_q;
  logic [NodeW-1:0] out_node_q;
  logic             out_err_q;
  logic             out_ovr_q;

  logic [CountW-1:0] count_sat;
  logic [WordW-1:0]  raw;
  logic [CountW-1:0] cnt;
  logic [CatW-1:0]   cat;
  logic              categorical;
  logic              cat_err;
  logic              go_right;
  logic [NodeW-1:0]  next_node;
  logic              last_move;

  // clamp written category count
  assign count_sat = (32'(category_count_i) > MaxCategories) ?
                     CountW'(MaxCategories) : category_count_i;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shuf_en_q   <= 1'b0;
      shuf_feat_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgShuffleEnable:  shuf_en_q   <= cfg_data_i[0];
        CfgShuffleFeature: shuf_feat_q <= cfg_data_i[FeatW-1:0];
        default: ;
      endcase
    end
  end

  // node memory: write on accept, registered read at the current node
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && func_e'(func_i) == FuncWriteNode) begin
      node_mem[node_index_i] <= '{leaf: node_is_terminal_i, feature: split_feature_i,
                                  word: split_word_i, left: left_child_i,
                                  right: right_child_i};
    end
    if (cmd_i.fetch_node) begin
      node_rd_q <= node_mem[node_q];
    end
  end

  // sample value and category count memories
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && func_e'(func_i) == FuncWriteValue) begin
      value_mem[feature_index_i] <= feature_value_i;
    end
    if (cmd_i.accept && func_e'(func_i) == FuncWriteCount) begin
      count_mem[feature_index_i] <= count_sat;
    end
    if (cmd_i.fetch_feat) begin
      value_rd_q <= value_mem[node_rd_q.feature];
      count_rd_q <= count_mem[node_rd_q.feature];
    end
  end

  // count valid bits, cleared by reset so unwritten counts read numeric
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_vld_q <= '0;
    end else if (cmd_i.accept && func_e'(func_i) == FuncWriteCount) begin
      count_vld_q[feature_index_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fetch_feat) begin
      count_vld_rd_q <= count_vld_q[node_rd_q.feature];
      shuf_hit_q     <= shuf_en_q && (node_rd_q.feature == shuf_feat_q);
    end
  end

  // split test
  always_comb begin
    raw         = shuf_hit_q ? shuf_val_q : value_rd_q;
    cnt         = count_vld_rd_q ? count_rd_q : '0;
    cat         = raw[WordW-1:FracBits];
    categorical = (cnt > CountW'(1));
    cat_err     = categorical && (raw[WordW-1] || (cat > CatW'(cnt)));
    if (categorical) begin
      go_right = (cat < CatW'(WordW)) && node_rd_q.word[cat[BitSelW-1:0]];
    end else begin
      go_right = $signed(raw) > $signed(node_rd_q.word);
    end
    next_node = go_right ? node_rd_q.right : node_rd_q.left;
  end

  assign last_move = (moves_q == NodeW'(Nodes - 1));

  // walk state and result
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      node_q     <= node_index_i;
      shuf_val_q <= shuffled_value_i;
      moves_q    <= '0;
      res_node_q <= '0;
      res_err_q  <= 1'b0;
      res_ovr_q  <= 1'b0;
    end
    if (cmd_i.take_leaf) begin
      res_node_q <= node_q;
    end
    if (cmd_i.eval_step) begin
      if (cat_err) begin
        res_node_q <= node_q;
        res_err_q  <= 1'b1;
      end else begin
        node_q  <= next_node;
        moves_q <= moves_q + 1'b1;
        if (last_move) begin
          res_node_q <= next_node;
          res_ovr_q  <= 1'b1;
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_node_q <= res_node_q;
      out_err_q  <= res_err_q;
      out_ovr_q  <= res_ovr_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign terminal_node_o  = out_node_q;
  assign category_error_o = out_err_q;
  assign walk_overrun_o   = out_ovr_q;

  // status
  assign sts_o.is_walk   = (func_e'(func_i) == FuncWalk);
  assign sts_o.is_leaf   = node_rd_q.leaf;
  assign sts_o.cat_err   = cat_err;
  assign sts_o.last_move = last_move;
  assign sts_o.out_free  = !out_valid_q || !out_stall_i;

  // a result never overwrites one still waiting
  a_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> (!out_valid_q || !out_stall_i))
    else $error("output overwritten");

  // a walk ends for one reason only
  a_one_reason: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> !(res_err_q && res_ovr_q))
    else $error("error and overrun together");

  // each move counts once
  a_move_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.eval_step && !cat_err) |=> moves_q == NodeW'($past(moves_q) + 1'b1))
    else $error("move count slip");

endmodule
